FILE: design/crlg_pkg.sv
// ----------------------------------------------------------------------------
// crlg_pkg
// Types and codes shared by the capability rate limit gate.
// ----------------------------------------------------------------------------
package crlg_pkg;

  localparam logic [1:0] OP_LOAD_CAP  = 2'd0;
  localparam logic [1:0] OP_LOAD_PROF = 2'd1;
  localparam logic [1:0] OP_AUTH      = 2'd2;

  localparam logic [2:0] DEC_ALLOWED = 3'd0;
  localparam logic [2:0] DEC_INVALID = 3'd1;
  localparam logic [2:0] DEC_DENIED  = 3'd2;
  localparam logic [2:0] DEC_BAD_ENC = 3'd3;
  localparam logic [2:0] DEC_BAD_LEN = 3'd4;
  localparam logic [2:0] DEC_RATE    = 3'd5;
  localparam logic [2:0] DEC_UNSUP   = 3'd6;

  localparam logic [1:0] CFG_CAP_COUNT  = 2'd0;
  localparam logic [1:0] CFG_PROF_COUNT = 2'd1;
  localparam logic [1:0] CFG_GATE       = 2'd2;

  localparam logic [4:0]  NO_SLOT   = 5'd16;
  localparam logic [47:0] MS_MAX    = 48'hFFFF_FFFF_FFFF;
  localparam logic [9:0]  MS_PER_S  = 10'd1000;

  typedef struct packed {
    logic [1:0]  op;
    logic [3:0]  entry_index;
    logic [3:0]  res_kind;
    logic [15:0] rsrc_id;
    logic [5:0]  ops_mask;
    logic [15:0] payload_cap;
    logic [15:0] rate_hz;
    logic [3:0]  call_code;
    logic        id_present;
    logic [1:0]  payload_state;
    logic [15:0] req_len;
    logic [47:0] now_ms;
  } req_t;

  typedef struct packed {
    logic [2:0]  decision;
    logic [4:0]  matched_slot;
    logic [15:0] granted_payload_cap;
    logic [15:0] granted_rate_hz;
    logic [15:0] seen_payload_len;
    logic [47:0] next_ok_ms;
  } rsp_t;

endpackage

FILE: design/capability_rate_limit_gate_core.sv
// ----------------------------------------------------------------------------
// capability_rate_limit_gate_core
// Gates host calls against profile and capability tables with rate limits.
// ----------------------------------------------------------------------------
// For an authorize item that needs them, the profile and capability tables
// are scanned one register entry per cycle, then the 1000/rate interval
// comes from a 10-step restoring divider. busy is high throughout; the
// result shows for one cycle on rsp with rsp_valid, and cannot be held.
// ----------------------------------------------------------------------------
module capability_rate_limit_gate_core
  import crlg_pkg::*;
#(
  parameter int MAX_CAPS    = 16,
  parameter int MAX_PROFILE = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  req_t        req,
  output logic        rsp_valid,
  output rsp_t        rsp,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [4:0]  cfg_data
);

  localparam int CW = (MAX_CAPS > 1) ? $clog2(MAX_CAPS) : 1;
  localparam int PW = (MAX_PROFILE > 1) ? $clog2(MAX_PROFILE) : 1;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_PROF = 6'b000010,
    S_CAP  = 6'b000100,
    S_DIV  = 6'b001000,
    S_RATE = 6'b010000,
    S_DONE = 6'b100000
  } state_t;

  state_t state;
  req_t   r;
  rsp_t   res;
  logic [4:0] cap_count, profile_count;
  logic       gate_installed;

  logic [3:0]  cap_kind [MAX_CAPS];
  logic [15:0] cap_rid  [MAX_CAPS];
  logic [5:0]  cap_ops  [MAX_CAPS];
  logic [15:0] cap_pcap [MAX_CAPS];
  logic [15:0] cap_rate [MAX_CAPS];
  logic [47:0] last_grant [MAX_CAPS];
  logic [MAX_CAPS-1:0] grant_seen;
  logic [3:0]  prof_kind [MAX_PROFILE];
  logic [15:0] prof_rid  [MAX_PROFILE];

  logic [6:0]  scan;
  logic [3:0]  kind;
  logic [5:0]  opbit;
  logic [CW-1:0] slot;
  logic [9:0]  quo, rem_q;
  logic [15:0] rem;
  logic [3:0]  dstep;
  logic [4:0]  pn, cn;
  logic        cap_hit, len_chk;

  assign busy = (state != S_IDLE);
  assign cfg_ready = !busy && !start;
  assign pn = (32'(profile_count) > MAX_PROFILE) ? 5'(MAX_PROFILE) : profile_count;
  assign cn = (32'(cap_count) > MAX_CAPS) ? 5'(MAX_CAPS) : cap_count;

  // first response of an item; go_scan when an authorize needs the tables
  rsp_t init_res;
  logic go_scan;
  always_comb begin
    init_res = '0;
    init_res.matched_slot = NO_SLOT;
    go_scan = 1'b0;
    if (req.op == OP_AUTH) begin
      if (!gate_installed) init_res.decision = DEC_DENIED;
      else if (req.call_code <= 4'd3) init_res.decision = DEC_ALLOWED;
      else if (req.call_code > 4'd9) init_res.decision = DEC_UNSUP;
      else if (!req.id_present) init_res.decision = DEC_BAD_ENC;
      else go_scan = 1'b1;
    end
  end

  assign cap_hit = cap_kind[CW'(scan)] == kind && cap_rid[CW'(scan)] == r.rsrc_id
                   && (cap_ops[CW'(scan)] & opbit) != 6'd0;
  assign len_chk = cap_pcap[CW'(scan)] != 16'd0 &&
                   (r.call_code == 4'd7 || r.call_code == 4'd9);

  logic [16:0] rem_sh;
  logic [47:0] nxt_sum;
  logic [48:0] nxt_raw;
  logic [9:0]  interval;
  assign rem_sh   = {rem, quo[9]};
  assign interval = (rem_q == 10'd0) ? 10'd1 : rem_q;
  assign nxt_raw  = {1'b0, last_grant[slot]} + {39'd0, interval};
  assign nxt_sum  = nxt_raw[48] ? MS_MAX : nxt_raw[47:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
      state <= S_IDLE;
      cap_count <= '0;
      profile_count <= '0;
      gate_installed <= 1'b0;
      grant_seen <= '0;
      for (int i = 0; i < MAX_CAPS; i++) last_grant[i] <= '0;
    end else begin
      rsp_valid <= (state == S_DONE);
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          CFG_CAP_COUNT:  cap_count <= cfg_data;
          CFG_PROF_COUNT: profile_count <= cfg_data;
          CFG_GATE:       gate_installed <= cfg_data[0];
          default: ;
        endcase
      end
      unique case (state)
        S_IDLE: begin
          if (start) begin
            r <= req;
            res <= init_res;
            scan <= '0;
            state <= go_scan ? S_PROF : S_DONE;
            if (req.op == OP_LOAD_CAP) begin
              if (32'(req.entry_index) < MAX_CAPS) begin
                cap_kind[CW'(req.entry_index)] <= req.res_kind;
                cap_rid[CW'(req.entry_index)]  <= req.rsrc_id;
                cap_ops[CW'(req.entry_index)]  <= req.ops_mask;
                cap_pcap[CW'(req.entry_index)] <= req.payload_cap;
                cap_rate[CW'(req.entry_index)] <= req.rate_hz;
                last_grant[CW'(req.entry_index)] <= '0;
                grant_seen[CW'(req.entry_index)] <= 1'b0;
              end
            end else if (req.op == OP_LOAD_PROF) begin
              if (32'(req.entry_index) < MAX_PROFILE) begin
                prof_kind[PW'(req.entry_index)] <= req.res_kind;
                prof_rid[PW'(req.entry_index)]  <= req.rsrc_id;
              end
            end else if (req.op == OP_AUTH) begin
              kind <= (req.call_code <= 4'd6) ? 4'd0 : 4'd1;
              unique case (req.call_code)
                4'd4: opbit <= 6'd1;
                4'd5: opbit <= 6'd2;
                4'd6, 4'd8: opbit <= 6'd4;
                4'd7: opbit <= 6'd8;
                default: opbit <= 6'd16;
              endcase
            end
          end
        end
        S_PROF: begin
          if (scan >= 7'(pn)) begin
            res.decision <= DEC_INVALID;
            state <= S_DONE;
          end else if (prof_rid[PW'(scan)] == r.rsrc_id) begin
            if (prof_kind[PW'(scan)] != kind) begin
              res.decision <= DEC_INVALID;
              state <= S_DONE;
            end else begin
              scan <= '0;
              state <= S_CAP;
            end
          end else begin
            scan <= scan + 7'd1;
          end
        end
        S_CAP: begin
          if (scan >= 7'(cn)) begin
            res.decision <= DEC_DENIED;
            state <= S_DONE;
          end else if (cap_hit) begin
            slot <= CW'(scan);
            res.matched_slot <= 5'(scan);
            res.granted_payload_cap <= cap_pcap[CW'(scan)];
            res.granted_rate_hz <= cap_rate[CW'(scan)];
            if (len_chk && r.payload_state[1]) begin
              res.decision <= DEC_BAD_ENC;
              state <= S_DONE;
            end else if (len_chk && r.payload_state[0] &&
                         r.req_len > cap_pcap[CW'(scan)]) begin
              res.decision <= DEC_BAD_LEN;
              res.seen_payload_len <= r.req_len;
              state <= S_DONE;
            end else begin
              res.seen_payload_len <= (len_chk && r.payload_state[0]) ? r.req_len : 16'd0;
              if (cap_rate[CW'(scan)] == 16'd0) begin
                res.decision <= DEC_ALLOWED;
                state <= S_DONE;
              end else begin
                quo <= MS_PER_S;
                rem <= '0;
                dstep <= '0;
                state <= S_DIV;
              end
            end
          end else begin
            scan <= scan + 7'd1;
          end
        end
        S_DIV: begin
          // restoring divide, quotient shifts into quo
          if (rem_sh >= {1'b0, res.granted_rate_hz}) begin
            rem <= 16'(rem_sh - {1'b0, res.granted_rate_hz});
            quo <= {quo[8:0], 1'b1};
          end else begin
            rem <= rem_sh[15:0];
            quo <= {quo[8:0], 1'b0};
          end
          dstep <= dstep + 4'd1;
          if (dstep == 4'd9) state <= S_RATE;
        end
        S_RATE: begin
          if (grant_seen[slot] && r.now_ms < nxt_sum) begin
            res.decision <= DEC_RATE;
            res.next_ok_ms <= nxt_sum;
          end else begin
            res.decision <= DEC_ALLOWED;
            res.next_ok_ms <= grant_seen[slot] ? nxt_sum : r.now_ms;
            last_grant[slot] <= r.now_ms;
            grant_seen[slot] <= 1'b1;
          end
          state <= S_DONE;
        end
        S_DONE: begin
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign rem_q = quo;
  assign rsp = res;

  a_busy_onehot: assert property (@(posedge clk) disable iff (rst) $onehot(state))
    else $error("state not one-hot");
  a_done_strobe: assert property (@(posedge clk) disable iff (rst)
    state == S_DONE |=> rsp_valid && state == S_IDLE) else $error("no strobe");
  a_strobe_src: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> $past(state) == S_DONE) else $error("stray strobe");
  a_rate_div: assert property (@(posedge clk) disable iff (rst)
    state == S_RATE |-> res.granted_rate_hz != 16'd0) else $error("div by zero");

endmodule
